// ----- rtl/udec_pkg.sv -----
// Shared types, codes and constants for the UTF-8 decoder.
package udec_pkg;

    localparam int CP_W             = 31;
    localparam int BYTE_W           = 8;
    localparam int LEAD_W           = 7;
    localparam int CONT_W           = 6;
    localparam int REM_W            = 3;
    localparam int QUEUE_DEPTH_DEF  = 4;

    // Result status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_BAD_LEAD  = 2'd1;
    localparam logic [1:0] STATUS_TRUNCATED = 2'd2;

    // Byte classes as seen outside a sequence
    localparam logic [1:0] KIND_ASCII = 2'd0;
    localparam logic [1:0] KIND_LEAD  = 2'd1;
    localparam logic [1:0] KIND_BAD   = 2'd2;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              end_of_text;
    } in_item_t;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic [1:0]      status;
        logic            final_item;
    } out_item_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic [REM_W-1:0]  lead_rem;
        logic [LEAD_W-1:0] lead_bits;
        logic [CONT_W-1:0] cont_bits;
        logic              end_of_text;
    } q_item_t;

endpackage

// ----- rtl/utf8_to_codepoint_decoder.sv -----
// Top level of the UTF-8 to code point decoder (legacy six-byte form).
//
//  channel   | signals                              | payload
//  ----------+--------------------------------------+---------------------------------
//  byte in   | byte_valid, byte_stall, byte_data    | data_byte, end_of_text
//  char out  | char_valid, char_stall, char_data    | code_point, status, final_item
//
// One byte transfer per cycle is sustained while the queue is not full; the back end retires
// one queued byte a cycle while the result register is free or being taken, and its
// shift-and-or update is a single step. A byte is written into the queue at its transfer; once
// it is at the head and the result register is free, any result it closes loads that register.
// Reset (rst_n low) empties the queue, clears the sequence state and drops char_valid.
// A stall on char_stall holds the result register; bytes keep filling the queue until
// it is full, then byte_stall rises.
module utf8_to_codepoint_decoder #(
    parameter int QUEUE_DEPTH = udec_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                byte_valid,
    output logic                byte_stall,
    input  udec_pkg::in_item_t  byte_data,
    output logic                char_valid,
    input  logic                char_stall,
    output udec_pkg::out_item_t char_data
);

    logic              q_push;
    logic              q_full;
    logic              q_pop;
    logic              head_valid;
    udec_pkg::q_item_t push_entry;
    udec_pkg::q_item_t head_entry;

    // Classify each byte by its top bits: ASCII, lead with its length, or bad lead.
    udec_front u_front (
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_data  (byte_data),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_entry    (push_entry)
    );

    // Decouple input transfers from output stalls.
    udec_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    // Track the open sequence and load the result register; advance only when it is free.
    udec_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (q_pop),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_data  (char_data)
    );

endmodule

// ----- rtl/udec_front.sv -----
// Front end: accepts bytes and classifies each one for the back end.
module udec_front (
    input  logic              byte_valid,
    output logic              byte_stall,
    input  udec_pkg::in_item_t byte_data,
    input  logic              q_full,
    output logic              q_push,
    output udec_pkg::q_item_t q_entry
);

    logic [7:0] b;

    assign b          = byte_data.data_byte;
    assign byte_stall = q_full;
    assign q_push     = byte_valid && !q_full;

    always_comb
    begin
        q_entry.cont_bits   = b[udec_pkg::CONT_W-1:0];
        q_entry.end_of_text = byte_data.end_of_text;
        q_entry.lead_bits   = b[udec_pkg::LEAD_W-1:0];
        q_entry.lead_rem    = 3'd0;
        q_entry.kind        = udec_pkg::KIND_BAD;
        case (b) inside
            [8'h00:8'h7F]:
            begin
                q_entry.kind = udec_pkg::KIND_ASCII;
            end
            [8'hC0:8'hDF]:
            begin
                q_entry.kind      = udec_pkg::KIND_LEAD;
                q_entry.lead_rem  = 3'd1;
                q_entry.lead_bits = {2'b00, b[4:0]};
            end
            [8'hE0:8'hEF]:
            begin
                q_entry.kind      = udec_pkg::KIND_LEAD;
                q_entry.lead_rem  = 3'd2;
                q_entry.lead_bits = {3'b000, b[3:0]};
            end
            [8'hF0:8'hF7]:
            begin
                q_entry.kind      = udec_pkg::KIND_LEAD;
                q_entry.lead_rem  = 3'd3;
                q_entry.lead_bits = {4'b0000, b[2:0]};
            end
            [8'hF8:8'hFB]:
            begin
                q_entry.kind      = udec_pkg::KIND_LEAD;
                q_entry.lead_rem  = 3'd4;
                q_entry.lead_bits = {5'b00000, b[1:0]};
            end
            [8'hFC:8'hFD]:
            begin
                q_entry.kind      = udec_pkg::KIND_LEAD;
                q_entry.lead_rem  = 3'd5;
                q_entry.lead_bits = {6'b000000, b[0]};
            end
            default:
            begin
                q_entry.kind = udec_pkg::KIND_BAD;
            end
        endcase
    end

endmodule

// ----- rtl/udec_queue.sv -----
// Short queue of classified bytes between front and back end.
module udec_queue #(
    parameter int DEPTH = udec_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  udec_pkg::q_item_t push_entry,
    output logic              full,
    input  logic              pop,
    output logic              head_valid,
    output udec_pkg::q_item_t head_entry
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    udec_pkg::q_item_t   slot_reg [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]    count_reg,  count_next;
    logic                do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = slot_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count above depth");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !do_pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not advance on push");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("empty queue with pointers apart");
`endif

endmodule

// ----- rtl/udec_back.sv -----
// Back end: gathers sequence bits and drives the registered result.
module udec_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               head_valid,
    input  udec_pkg::q_item_t  head_entry,
    output logic               pop,
    output logic               char_valid,
    input  logic               char_stall,
    output udec_pkg::out_item_t char_data
);

    logic [udec_pkg::REM_W-1:0] rem_reg,  rem_next;
    logic [udec_pkg::CP_W-1:0]  part_reg, part_next;
    logic                       out_valid_reg, out_valid_next;
    udec_pkg::out_item_t        out_reg, out_next;
    logic [udec_pkg::CP_W-1:0]  shifted;
    logic [udec_pkg::REM_W-1:0] rem_dec;
    logic                       emit;

    assign pop        = head_valid && (!out_valid_reg || !char_stall);
    assign char_valid = out_valid_reg;
    assign char_data  = out_reg;
    assign shifted    = {part_reg[udec_pkg::CP_W-udec_pkg::CONT_W-1:0], head_entry.cont_bits};
    assign rem_dec    = rem_reg - 1'b1;

    always_comb
    begin
        rem_next  = rem_reg;
        part_next = part_reg;
        emit      = 1'b0;
        out_next  = out_reg;
        if (pop)
        begin
            if (rem_reg == '0)
            begin
                case (head_entry.kind)
                    udec_pkg::KIND_ASCII:
                    begin
                        emit     = 1'b1;
                        out_next = '{code_point: udec_pkg::CP_W'(head_entry.lead_bits),
                                     status: udec_pkg::STATUS_OK,
                                     final_item: head_entry.end_of_text};
                    end
                    udec_pkg::KIND_LEAD:
                    begin
                        if (head_entry.end_of_text)
                        begin
                            emit     = 1'b1;
                            out_next = '{code_point: '0,
                                         status: udec_pkg::STATUS_TRUNCATED,
                                         final_item: 1'b1};
                        end
                        else
                        begin
                            part_next = udec_pkg::CP_W'(head_entry.lead_bits);
                            rem_next  = head_entry.lead_rem;
                        end
                    end
                    default:
                    begin
                        emit     = 1'b1;
                        out_next = '{code_point: '0,
                                     status: udec_pkg::STATUS_BAD_LEAD,
                                     final_item: head_entry.end_of_text};
                    end
                endcase
            end
            else if (rem_dec == '0)
            begin
                emit      = 1'b1;
                out_next  = '{code_point: shifted,
                              status: udec_pkg::STATUS_OK,
                              final_item: head_entry.end_of_text};
                part_next = '0;
                rem_next  = '0;
            end
            else if (head_entry.end_of_text)
            begin
                emit      = 1'b1;
                out_next  = '{code_point: '0,
                              status: udec_pkg::STATUS_TRUNCATED,
                              final_item: 1'b1};
                part_next = '0;
                rem_next  = '0;
            end
            else
            begin
                part_next = shifted;
                rem_next  = rem_dec;
            end
        end
        // drop the valid once taken unless a fresh result replaces it
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !char_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg       <= '0;
            part_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rem_reg       <= rem_next;
            part_reg      <= part_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

`ifndef SYNTHESIS
    a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (rem_reg == '0) |-> (part_reg == '0))
        else $error("partial value left over while idle");

    a_trunc_final: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.status == udec_pkg::STATUS_TRUNCATED)
            |-> (out_reg.final_item && out_reg.code_point == '0))
        else $error("truncation result not closing the string");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rem_reg <= 3'd5)
        else $error("remaining count above five");
`endif

endmodule

// ----- test/tb_utf8_to_codepoint_decoder.sv -----
// Self-checking testbench for the UTF-8 to code point decoder: directed table plus random text.
module tb_utf8_to_codepoint_decoder;

    localparam int DIRECTED_ROWS = 26;
    localparam int RANDOM_BYTES  = 1250;
    localparam int QUIET_LIMIT   = 2000;  // cycles with no transfer on either channel
    localparam int DRAIN_CYCLES  = 20;    // lets stray output show up after the last expected char
    localparam int REPORT_MAX    = 10;

    // One planned byte transfer; want holds a hand-written result for table rows
    // where it is obvious, otherwise the predictor supplies it.
    typedef struct packed {
        udec_pkg::in_item_t  b;
        logic                typed;
        udec_pkg::out_item_t want;
    } byte_row_t;

    logic                clk;
    logic                rst_n      = 1'b0;
    logic                byte_valid = 1'b0;
    logic                byte_stall;
    udec_pkg::in_item_t  byte_data  = '0;
    logic                char_valid;
    logic                char_stall = 1'b0;
    udec_pkg::out_item_t char_data;

    // Predictor state: continuation bytes still owed and the value built so far.
    logic [udec_pkg::REM_W-1:0] seq_left  = '0;
    logic [udec_pkg::CP_W-1:0]  seq_value = '0;

    udec_pkg::out_item_t pending_chars[$];
    byte_row_t           byte_plan[$];
    int unsigned         fault_count  = 0;
    int unsigned         result_count = 0;
    int unsigned         recv_wait    = 0;
    bit                  recv_burst   = 1'b0;

    // Table: extremes, the edge bad leads (80, BF, FE, FF), lead truncation, each sequence length,
    // unchecked continuation bytes and truncation in the middle of a sequence.
    byte_row_t directed_rows [0:DIRECTED_ROWS-1] = '{
        '{'{8'h00, 1'b0}, 1'b1, '{31'h0,  udec_pkg::STATUS_OK,        1'b0}},
        '{'{8'h7F, 1'b1}, 1'b1, '{31'h7F, udec_pkg::STATUS_OK,        1'b1}},
        '{'{8'h80, 1'b0}, 1'b1, '{31'h0,  udec_pkg::STATUS_BAD_LEAD,  1'b0}},
        '{'{8'hBF, 1'b1}, 1'b1, '{31'h0,  udec_pkg::STATUS_BAD_LEAD,  1'b1}},
        '{'{8'hFE, 1'b0}, 1'b1, '{31'h0,  udec_pkg::STATUS_BAD_LEAD,  1'b0}},
        '{'{8'hFF, 1'b1}, 1'b1, '{31'h0,  udec_pkg::STATUS_BAD_LEAD,  1'b1}},
        '{'{8'hC0, 1'b1}, 1'b1, '{31'h0,  udec_pkg::STATUS_TRUNCATED, 1'b1}},
        // overlong two-byte zero
        '{'{8'hC0, 1'b0}, 1'b0, '0},
        '{'{8'h80, 1'b0}, 1'b0, '0},
        // three-byte maximum, closing the string
        '{'{8'hEF, 1'b0}, 1'b0, '0},
        '{'{8'hBF, 1'b0}, 1'b0, '0},
        '{'{8'hBF, 1'b1}, 1'b0, '0},
        // four-byte sequence cut short by end of text
        '{'{8'hF0, 1'b0}, 1'b0, '0},
        '{'{8'h90, 1'b0}, 1'b0, '0},
        '{'{8'h80, 1'b1}, 1'b0, '0},
        // five-byte minimum lead
        '{'{8'hF8, 1'b0}, 1'b0, '0},
        '{'{8'h88, 1'b0}, 1'b0, '0},
        '{'{8'h80, 1'b0}, 1'b0, '0},
        '{'{8'h80, 1'b0}, 1'b0, '0},
        '{'{8'h80, 1'b0}, 1'b0, '0},
        // six-byte maximum, continuations of any shape
        '{'{8'hFD, 1'b0}, 1'b0, '0},
        '{'{8'hFF, 1'b0}, 1'b0, '0},
        '{'{8'h3F, 1'b0}, 1'b0, '0},
        '{'{8'h7F, 1'b0}, 1'b0, '0},
        '{'{8'hBF, 1'b0}, 1'b0, '0},
        '{'{8'hFF, 1'b1}, 1'b0, '0}
    };

    utf8_to_codepoint_decoder u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_data  (byte_data),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_data  (char_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Advance the predicted decoder by one byte; return 1 when the byte closes a
    // character, a bad lead or a truncated string.
    function automatic bit decode_step(input udec_pkg::in_item_t b,
                                       output udec_pkg::out_item_t ch);
        int unsigned len;
        ch = '0;
        if (seq_left == 0)
        begin
            if (!b.data_byte[7])
            begin
                ch.code_point = udec_pkg::CP_W'(b.data_byte);
                ch.status     = udec_pkg::STATUS_OK;
                ch.final_item = b.end_of_text;
                return 1'b1;
            end
            casez (b.data_byte)
                8'b110?????: len = 2;
                8'b1110????: len = 3;
                8'b11110???: len = 4;
                8'b111110??: len = 5;
                8'b1111110?: len = 6;
                default:     len = 0;
            endcase
            if (len == 0)
            begin
                ch.status     = udec_pkg::STATUS_BAD_LEAD;
                ch.final_item = b.end_of_text;
                return 1'b1;
            end
            if (b.end_of_text)
            begin
                seq_value     = '0;
                ch.status     = udec_pkg::STATUS_TRUNCATED;
                ch.final_item = 1'b1;
                return 1'b1;
            end
            seq_value = udec_pkg::CP_W'(int'(b.data_byte) & ((1 << (7 - len)) - 1));
            seq_left  = udec_pkg::REM_W'(len - 1);
            return 1'b0;
        end
        // Shift in six bits; anything inside a sequence counts as a continuation.
        seq_value = {seq_value[udec_pkg::CP_W-udec_pkg::CONT_W-1:0],
                     b.data_byte[udec_pkg::CONT_W-1:0]};
        seq_left  = seq_left - 1'b1;
        if (seq_left == 0)
        begin
            ch.code_point = seq_value;
            ch.status     = udec_pkg::STATUS_OK;
            ch.final_item = b.end_of_text;
            seq_value     = '0;
            return 1'b1;
        end
        if (b.end_of_text)
        begin
            seq_left      = '0;
            seq_value     = '0;
            ch.status     = udec_pkg::STATUS_TRUNCATED;
            ch.final_item = 1'b1;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic int unsigned draw_wait(input bit burst);
        return burst ? 0 : $urandom_range(0, 12);
    endfunction

    function automatic void plan_byte(input logic [7:0] value, input logic eot);
        byte_row_t row;
        row.b.data_byte   = value;
        row.b.end_of_text = eot;
        row.typed         = 1'b0;
        row.want          = '0;
        byte_plan.push_back(row);
    endfunction

    // Present one byte after an idle gap, hold it until the transfer, then
    // record what the decoder must produce for it.
    task automatic send_byte(input byte_row_t row, input int unsigned gap);
        udec_pkg::out_item_t ch;
        bit                  closes;
        if (gap != 0)
        begin
            byte_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_valid <= 1'b1;
        byte_data  <= row.b;
        do @(posedge clk); while (byte_stall);
        closes = decode_step(row.b, ch);
        if (row.typed)
            pending_chars.push_back(row.want);
        else if (closes)
            pending_chars.push_back(ch);
    endtask

    // Receive side: check every char transfer against the oldest expectation,
    // then draw how long to hold off the next one.
    always @(posedge clk)
    begin
        udec_pkg::out_item_t want;
        if (rst_n)
        begin
            if (char_valid && !char_stall)
            begin
                if (pending_chars.size() == 0)
                begin
                    fault_count++;
                    if (fault_count <= REPORT_MAX)
                        $display("unexpected char: cp=%h status=%0d final=%0b",
                                 char_data.code_point, char_data.status,
                                 char_data.final_item);
                end
                else
                begin
                    want = pending_chars.pop_front();
                    if (char_data.code_point !== want.code_point
                            || char_data.status !== want.status
                            || char_data.final_item !== want.final_item)
                    begin
                        fault_count++;
                        if (fault_count <= REPORT_MAX)
                            $display({"char %0d mismatch: expected cp=%h status=%0d ",
                                      "final=%0b, got cp=%h status=%0d final=%0b"},
                                     result_count, want.code_point, want.status,
                                     want.final_item, char_data.code_point,
                                     char_data.status, char_data.final_item);
                    end
                end
                result_count++;
                if (result_count % 64 == 0)
                    recv_burst = ($urandom_range(0, 3) == 0);
                recv_wait = draw_wait(recv_burst);
            end
            char_stall <= (recv_wait != 0);
            if (recv_wait != 0)
                recv_wait--;
        end
    end

    // Watchdog: drop the run once neither channel has moved for too long.
    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (byte_valid && !byte_stall) || (char_valid && !char_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin : stimulus
        int unsigned kind;
        int unsigned len;
        int unsigned cont_n;
        int unsigned k;
        int unsigned idx;
        logic [7:0]  lead;
        logic [7:0]  cont;
        bit          send_burst;

        foreach (directed_rows[r])
            byte_plan.push_back(directed_rows[r]);

        // Mostly well-formed characters with random content, some sequences with
        // their tail dropped, the rest raw noise; end of text lands anywhere.
        while (byte_plan.size() < DIRECTED_ROWS + RANDOM_BYTES)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 85)
            begin
                k   = $urandom_range(0, 7);
                len = (k >= 6) ? 1 : k + 1;
                if (len == 1)
                begin
                    lead = 8'($urandom_range(0, 127));
                end
                else
                begin
                    lead = 8'hFF << (8 - len);
                    lead = lead | 8'($urandom_range(0, (1 << (7 - len)) - 1));
                end
                cont_n = (kind >= 75 && len > 1) ? $urandom_range(0, len - 2) : len - 1;
                plan_byte(lead, (cont_n == 0) ? ($urandom_range(0, 7) == 0)
                                              : ($urandom_range(0, 24) == 0));
                for (k = 1; k <= cont_n; k++)
                begin
                    if ($urandom_range(0, 15) == 0)
                        cont = 8'($urandom_range(0, 255));
                    else
                        cont = 8'h80 | 8'($urandom_range(0, 63));
                    plan_byte(cont, (k == cont_n) ? ($urandom_range(0, 7) == 0)
                                                  : ($urandom_range(0, 24) == 0));
                end
            end
            else
            begin
                plan_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
            end
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_burst = 1'b0;
        for (idx = 0; idx < byte_plan.size(); idx++)
        begin
            if (idx % 64 == 0)
                send_burst = ($urandom_range(0, 3) == 0);
            send_byte(byte_plan[idx], draw_wait(send_burst));
        end
        byte_valid <= 1'b0;

        // Drain: wait for every expected char, then let stray output show up.
        while (pending_chars.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fault_count == 0 && pending_chars.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
